// ===== hw/rtl/fsd_pkg.sv =====
// Shared types and constants for the Floyd-Steinberg palette dither.
// Used by fsd_quant, floyd_steinberg_palette_dither and tb_top; depends on nothing.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int N_CHAN = 3;
  localparam int CFG_W  = 12;
  // Width of a stored below-error (magnitude at most 15).
  localparam int ERR_W  = 6;
  // Width of one weighted error term (magnitude at most 11).
  localparam int TERM_W = 5;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd1080;

  localparam logic [7:0] BLUE_STRIDE  = 8'd42;
  localparam logic [7:0] GREEN_STRIDE = 8'd6;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic       frame_end;
  } result_t;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // Lane 0 is blue, lane 1 green, lane 2 red.
  typedef err_t  [N_CHAN-1:0] err3_t;
  typedef term_t [N_CHAN-1:0] term3_t;

  typedef struct packed {
    term_t east_term;
    term_t sw_term;
    term_t s_term;
    term_t se_term;
  } terms_t;

  typedef terms_t [N_CHAN-1:0] terms3_t;

endpackage

// ===== hw/rtl/fsd_quant.sv =====
// Per-pixel datapath: error correction, saturation, quantisation and weighting.
// Purely combinational; depends on fsd_pkg.
`timescale 1ns / 1ps

module fsd_quant (
  input  fsd_pkg::pixel_t  pix_i,
  input  fsd_pkg::err3_t   line_i,
  input  fsd_pkg::term3_t  east_i,
  output logic [7:0]       index_o,
  output fsd_pkg::terms3_t terms_o
);
  import fsd_pkg::*;

  localparam int SUM_W = 10;
  localparam int GREEN_LANE = 1;

  localparam logic [3:0] W_EAST = 4'd7;
  localparam logic [3:0] W_SW   = 4'd3;
  localparam logic [3:0] W_S    = 4'd5;
  localparam logic [3:0] W_SE   = 4'd1;

  localparam logic [7:0] BR_STEP = 8'd51;
  // Lowest value that rounds up to each next level.
  localparam logic [7:0] BR_THR [5] = '{8'd26, 8'd77, 8'd128, 8'd179, 8'd230};
  localparam logic [7:0] GREEN_THR [6] = '{8'd22, 8'd64, 8'd107, 8'd149, 8'd192, 8'd234};

  function automatic logic [7:0] green_level(input logic [2:0] gi);
    logic [7:0] lv;
    unique case (gi)
      3'd0: lv = 8'd0;
      3'd1: lv = 8'd43;
      3'd2: lv = 8'd85;
      3'd3: lv = 8'd128;
      3'd4: lv = 8'd170;
      3'd5: lv = 8'd213;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  // Rounds mag*w/16 half away from zero and restores the sign.
  function automatic term_t weigh(input logic [4:0] mag, input logic neg,
                                  input logic [3:0] w);
    logic [8:0] t;
    term_t      res;
    t   = 9'(mag) * 9'(w) + 9'd8;
    res = term_t'({1'b0, t[7:4]});
    return neg ? -res : res;
  endfunction

  logic [N_CHAN-1:0][7:0] chan;
  logic [N_CHAN-1:0][2:0] idx;

  assign chan = {pix_i.red, pix_i.green, pix_i.blue};

  for (genvar g = 0; g < N_CHAN; g++) begin : g_lane
    logic signed [SUM_W-1:0] sum;
    logic [7:0]              v;
    logic [7:0]              level;
    logic signed [8:0]       diff;
    err_t                    e;
    logic                    neg;
    logic [4:0]              mag;

    always_comb begin
      sum = SUM_W'(signed'({2'b00, chan[g]})) + SUM_W'(line_i[g]) + SUM_W'(east_i[g]);
      if (sum < 0) begin
        v = 8'd0;
      end else if (sum > SUM_W'(255)) begin
        v = 8'd255;
      end else begin
        v = sum[7:0];
      end
    end

    if (g == GREEN_LANE) begin : g_green
      always_comb begin
        idx[g] = 3'd0;
        for (int k = 0; k < 6; k++) begin
          if (v >= GREEN_THR[k]) idx[g] = 3'(k + 1);
        end
        level = green_level(idx[g]);
      end
    end else begin : g_br
      always_comb begin
        idx[g] = 3'd0;
        for (int k = 0; k < 5; k++) begin
          if (v >= BR_THR[k]) idx[g] = 3'(k + 1);
        end
        level = 8'(8'(idx[g]) * BR_STEP);
      end
    end

    always_comb begin
      diff = signed'({1'b0, v}) - signed'({1'b0, level});
      e    = ERR_W'(diff);
      neg  = e[ERR_W-1];
      mag  = neg ? 5'(-e) : 5'(e);
      terms_o[g].east_term = weigh(mag, neg, W_EAST);
      terms_o[g].sw_term   = weigh(mag, neg, W_SW);
      terms_o[g].s_term    = weigh(mag, neg, W_S);
      terms_o[g].se_term   = weigh(mag, neg, W_SE);
    end
  end

  assign index_o = 8'(8'(idx[0]) * BLUE_STRIDE + 8'(idx[1]) * GREEN_STRIDE + 8'(idx[2]));

endmodule

// ===== hw/rtl/floyd_steinberg_palette_dither.sv =====
// Top level of the Floyd-Steinberg dither onto the 252-colour palette.
// Holds the row error memory, pixel counters and output queue; depends on
// fsd_pkg and fsd_quant.
//
// Usage: pixels arrive in raster order on the in_ channel, one BGR word per
// accepted transfer (in_valid_i high, in_stall_o low). Each pixel yields one
// word on the out_ channel: its palette index and a flag on the last pixel of
// the frame. The cfg_ channel sets the frame size; cfg_ready_o is always high
// and writes are meant for when no pixel is in flight.
// Flow: an accepted word is registered into the second stage, whose result is
// written into the output queue and leaves from there. Throughput is one pixel
// per clock while in_stall_o is low, set by the east-error feedback around the
// quantiser in the second stage; the row memory is read on acceptance and
// written back by the second stage, with forwarding for very narrow frames.
// When the receiver stalls, up to three results wait in the output queue and
// in_stall_o rises once queue plus second stage hold three pixels.
// Reset clears the counters, the carried errors and the queue and loads a
// 1920 x 1080 frame size. The row memory is not cleared: the first row of a
// frame never reads it.
`timescale 1ns / 1ps

module floyd_steinberg_palette_dither #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fsd_pkg::pixel_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fsd_pkg::result_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [fsd_pkg::CFG_W-1:0]     cfg_data_i
);
  import fsd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LW    = CFG_W + 1;
  localparam int OQ_DEPTH = 3;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } pos_t;

  // Configuration.
  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic [LW-1:0]    w_eff, h_eff;

  // Frame position.
  logic [COL_W-1:0] col_q, col_d;
  logic [CFG_W-1:0] row_q, row_d;
  pos_t             pos_a;
  logic             in_accept;

  // Second stage.
  logic             b_valid_q, b_valid_d;
  pixel_t           b_pix_q;
  logic [COL_W-1:0] b_col_q;
  pos_t             b_pos_q;

  // Row error memory and its forwarding registers.
  err3_t            line_mem [MAX_WIDTH];
  err3_t            line_rd_q;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  err3_t            mem_wdata;
  logic             lastw_valid_q;
  logic [COL_W-1:0] lastw_addr_q;
  err3_t            lastw_data_q;
  logic             tail_valid_q, tail_valid_d;
  logic [COL_W-1:0] tail_addr_q, tail_addr_d;
  err3_t            tail_data_q, tail_data_d;
  err3_t            line_fwd, line_use;

  // Carried errors.
  term3_t           east_q, east_d;
  err3_t            pend0_q, pend0_d, pend1_q, pend1_d;
  err3_t            pend0_new, sw_data;

  // Datapath results.
  logic [7:0]       index;
  terms3_t          terms;
  logic             main_we;
  logic [COL_W-1:0] main_addr;
  err3_t            main_data;
  result_t          result;

  // Output queue.
  result_t          q_mem [OQ_DEPTH];
  logic [1:0]       q_wr_q, q_wr_d, q_rd_q, q_rd_d, q_cnt_q, q_cnt_d;
  logic             q_push, q_pop;

  // ---------------------------------------------------------------------------
  // Configuration port

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_d  = cfg_data_i;
        REG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = LW'(1);
    end else if (LW'(width_q) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(width_q);
    end
    h_eff = (height_q == '0) ? LW'(1) : LW'(height_q);
  end

  // ---------------------------------------------------------------------------
  // First stage: position and memory read

  assign in_stall_o = (3'(q_cnt_q) + 3'(b_valid_q)) >= 3'(OQ_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    pos_a.first_col = (col_q == '0);
    pos_a.last_col  = (LW'(col_q) + LW'(1)) >= w_eff;
    pos_a.first_row = (row_q == '0);
    pos_a.last_row  = (LW'(row_q) + LW'(1)) >= h_eff;

    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (pos_a.last_col) begin
        col_d = '0;
        row_d = pos_a.last_row ? '0 : CFG_W'(row_q + 1'b1);
      end else begin
        col_d = COL_W'(col_q + 1'b1);
      end
    end
  end

  assign b_valid_d = in_accept;

  // ---------------------------------------------------------------------------
  // Second stage: correct, quantise and spread the error

  // A write landing on the edge of the read, or still waiting in the tail
  // register, is newer than what the memory returned.
  always_comb begin
    if (tail_valid_q && tail_addr_q == b_col_q) begin
      line_fwd = tail_data_q;
    end else if (lastw_valid_q && lastw_addr_q == b_col_q) begin
      line_fwd = lastw_data_q;
    end else begin
      line_fwd = line_rd_q;
    end
    line_use = b_pos_q.first_row ? '0 : line_fwd;
  end

  fsd_quant u_quant (
    .pix_i   (b_pix_q),
    .line_i  (line_use),
    .east_i  (east_q),
    .index_o (index),
    .terms_o (terms)
  );

  always_comb begin
    for (int ch = 0; ch < N_CHAN; ch++) begin
      pend0_new[ch] = pend1_q[ch] + ERR_W'(terms[ch].s_term);
      sw_data[ch]   = pend0_q[ch] + ERR_W'(terms[ch].sw_term);
    end
  end

  // The south-west write goes to column c-1. On the last column the finished
  // column c needs a second write, which waits in the tail register; the next
  // pixel is in column zero and leaves the port free.
  always_comb begin
    main_we   = 1'b0;
    main_addr = b_col_q;
    main_data = pend0_new;
    tail_valid_d = tail_valid_q;
    tail_addr_d  = tail_addr_q;
    tail_data_d  = tail_data_q;

    if (b_valid_q && !b_pos_q.last_row) begin
      if (!b_pos_q.first_col) begin
        main_we   = 1'b1;
        main_addr = COL_W'(b_col_q - 1'b1);
        main_data = sw_data;
      end else if (b_pos_q.last_col) begin
        main_we = 1'b1;
      end
    end

    if (!main_we && tail_valid_q) begin
      tail_valid_d = 1'b0;
    end
    if (b_valid_q && !b_pos_q.last_row && b_pos_q.last_col && !b_pos_q.first_col) begin
      tail_valid_d = 1'b1;
      tail_addr_d  = b_col_q;
      tail_data_d  = pend0_new;
    end
  end

  always_comb begin
    mem_we    = main_we || tail_valid_q;
    mem_waddr = main_we ? main_addr : tail_addr_q;
    mem_wdata = main_we ? main_data : tail_data_q;
  end

  always_comb begin
    east_d  = east_q;
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    if (b_valid_q) begin
      for (int ch = 0; ch < N_CHAN; ch++) begin
        east_d[ch] = b_pos_q.last_col ? '0 : terms[ch].east_term;
        if (!b_pos_q.last_row) begin
          pend0_d[ch] = pend0_new[ch];
          pend1_d[ch] = b_pos_q.last_col ? '0 : ERR_W'(terms[ch].se_term);
        end
        if (b_pos_q.last_col) begin
          pend0_d[ch] = '0;
          pend1_d[ch] = '0;
        end
      end
    end
  end

  assign result.palette_index = index;
  assign result.frame_end     = b_pos_q.last_col && b_pos_q.last_row;

  // ---------------------------------------------------------------------------
  // Output queue

  assign q_push      = b_valid_q;
  assign out_valid_o = (q_cnt_q != '0);
  assign q_pop       = out_valid_o && !out_stall_i;
  assign out_data_o  = q_mem[q_rd_q];

  always_comb begin
    q_wr_d  = q_wr_q;
    q_rd_d  = q_rd_q;
    if (q_push) begin
      q_wr_d = (q_wr_q == 2'(OQ_DEPTH - 1)) ? '0 : 2'(q_wr_q + 1'b1);
    end
    if (q_pop) begin
      q_rd_d = (q_rd_q == 2'(OQ_DEPTH - 1)) ? '0 : 2'(q_rd_q + 1'b1);
    end
    q_cnt_d = 2'(q_cnt_q + 2'(q_push) - 2'(q_pop));
  end

  // ---------------------------------------------------------------------------
  // Registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= WIDTH_RESET;
      height_q      <= HEIGHT_RESET;
      col_q         <= '0;
      row_q         <= '0;
      b_valid_q     <= 1'b0;
      lastw_valid_q <= 1'b0;
      tail_valid_q  <= 1'b0;
      east_q        <= '0;
      pend0_q       <= '0;
      pend1_q       <= '0;
      q_wr_q        <= '0;
      q_rd_q        <= '0;
      q_cnt_q       <= '0;
    end else begin
      width_q       <= width_d;
      height_q      <= height_d;
      col_q         <= col_d;
      row_q         <= row_d;
      b_valid_q     <= b_valid_d;
      lastw_valid_q <= mem_we;
      tail_valid_q  <= tail_valid_d;
      east_q        <= east_d;
      pend0_q       <= pend0_d;
      pend1_q       <= pend1_d;
      q_wr_q        <= q_wr_d;
      q_rd_q        <= q_rd_d;
      q_cnt_q       <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_pix_q <= in_data_i;
      b_col_q <= col_q;
      b_pos_q <= pos_a;
    end
    lastw_addr_q <= mem_waddr;
    lastw_data_q <= mem_wdata;
    tail_addr_q  <= tail_addr_d;
    tail_data_q  <= tail_data_d;
    if (q_push) begin
      q_mem[q_wr_q] <= result;
    end
  end

  // Row error memory: one write and one read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      line_rd_q <= line_mem[col_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions

  // The second stage always finds room in the output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> q_cnt_q != 2'(OQ_DEPTH))
    else $error("output queue overflow");

  // The deferred end-of-row write drains as soon as the port is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid_q && !b_valid_q |=> !tail_valid_q)
    else $error("tail write not drained");

  // Nothing is carried past the end of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_pos_q.last_col |=> east_q == '0 && pend0_q == '0 && pend1_q == '0)
    else $error("errors carried across a row boundary");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for floyd_steinberg_palette_dither: drives BGR pixel words,
// predicts every palette word in a behavioural model and compares them in order.
// Depends on fsd_pkg and the floyd_steinberg_palette_dither RTL only.
`timescale 1ns / 1ps

module tb_top;
  import fsd_pkg::*;

  localparam int MAX_W       = 2048;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit       is_write;
    cfg_reg_e reg_sel;
    logic [CFG_W-1:0] value;
    pixel_t   px;
    bit       typed;
    result_t  want;
  } step_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  pixel_t           in_data   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  logic    in_stall_o;
  logic    out_valid_o;
  result_t out_data_o;
  logic    cfg_ready_o;

  // Dither state as the block should hold it.
  int frame_w = int'(WIDTH_RESET);
  int frame_h = int'(HEIGHT_RESET);
  int col_pos = 0;
  int row_pos = 0;
  int below_line [MAX_W][3];
  int east_carry [3];
  int below_pend [2][3];

  result_t palette_due [$];
  step_t   plan [$];
  int      mismatches     = 0;
  int      cycles         = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  bit      quiet          = 1'b0;
  result_t want_out;

  floyd_steinberg_palette_dither #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (palette_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want_out = palette_due.pop_front();
        if (out_data_o.palette_index !== want_out.palette_index) begin
          $display("%0t: palette_index expected %0d got %0d", $time,
                   want_out.palette_index, out_data_o.palette_index);
          mismatches++;
        end
        if (out_data_o.frame_end !== want_out.frame_end) begin
          $display("%0t: frame_end expected %0d got %0d", $time,
                   want_out.frame_end, out_data_o.frame_end);
          mismatches++;
        end
      end
    end
  end

  // One weighted error term, rounded half away from zero.
  function automatic int weighted(int e, int wt);
    int mag;
    mag = (e < 0) ? -e : e;
    mag = (mag * wt + 8) / 16;
    return (e < 0) ? -mag : mag;
  endfunction

  function automatic result_t dither_pixel(pixel_t px);
    int w, h, c, ch, v, lvl, e;
    int qi [3];
    int chan [3];
    bit first_col, last_col, first_row, last_row;
    result_t res;
    w = frame_w;
    h = frame_h;
    c = col_pos;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    if (c >= MAX_W) c = MAX_W - 1;
    first_col = (c == 0);
    last_col  = (c + 1 >= w);
    first_row = (row_pos == 0);
    last_row  = (row_pos + 1 >= h);
    chan[0] = int'(px.blue);
    chan[1] = int'(px.green);
    chan[2] = int'(px.red);
    for (ch = 0; ch < 3; ch++) begin
      v = chan[ch] + east_carry[ch] + (first_row ? 0 : below_line[c][ch]);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      if (ch == 1) begin
        // Green levels are idx*42.5 rounded half up.
        qi[ch] = (2 * v + 42) / 85;
        lvl    = (qi[ch] * 85 + 1) / 2;
      end else begin
        qi[ch] = (v + 25) / 51;
        lvl    = qi[ch] * 51;
      end
      e = v - lvl;
      east_carry[ch] = last_col ? 0 : weighted(e, 7);
      if (!last_row) begin
        if (!first_col) below_line[c-1][ch] = below_pend[0][ch] + weighted(e, 3);
        below_pend[0][ch] = below_pend[1][ch] + weighted(e, 5);
        below_pend[1][ch] = last_col ? 0 : weighted(e, 1);
        if (last_col) below_line[c][ch] = below_pend[0][ch];
      end
      if (last_col) begin
        below_pend[0][ch] = 0;
        below_pend[1][ch] = 0;
      end
    end
    res.palette_index = 8'(qi[0] * int'(BLUE_STRIDE) + qi[1] * int'(GREEN_STRIDE) + qi[2]);
    res.frame_end     = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 'hFFF);
    end else begin
      col_pos = (c + 1) & 'h7FF;
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.blue  = rand_channel();
    px.green = rand_channel();
    px.red   = rand_channel();
    return px;
  endfunction

  function automatic step_t mk_pixel(int b, int g, int r);
    step_t s;
    s.is_write = 1'b0;
    s.reg_sel  = REG_WIDTH;
    s.value    = '0;
    s.px       = '{blue: 8'(b), green: 8'(g), red: 8'(r)};
    s.typed    = 1'b0;
    s.want     = '0;
    return s;
  endfunction

  function automatic step_t mk_checked(int b, int g, int r, int idx, bit fe);
    step_t s;
    s       = mk_pixel(b, g, r);
    s.typed = 1'b1;
    s.want  = '{palette_index: 8'(idx), frame_end: fe};
    return s;
  endfunction

  function automatic step_t mk_write(cfg_reg_e sel, int val);
    step_t s;
    s          = mk_pixel(0, 0, 0);
    s.is_write = 1'b1;
    s.reg_sel  = sel;
    s.value    = CFG_W'(val);
    return s;
  endfunction

  task automatic send_pixel(pixel_t px, bit typed, result_t want);
    result_t model_out;
    @(negedge clk);
    if ($urandom_range(0, 99) < 2) quiet = !quiet;
    while (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    model_out = dither_pixel(px);
    palette_due.push_back(typed ? want : model_out);
  endtask

  // Hold the input back until every palette word has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (palette_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e sel, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (sel == REG_WIDTH) frame_w = int'(val);
    else frame_h = int'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Close any open frame by shrinking it to one pixel, so that later widths
  // may grow without the row memory being read before it is written.
  task automatic close_frame();
    if (col_pos != 0 || row_pos != 0) begin
      write_frame(12'd1, 12'd1);
      send_pixel(rand_pixel(), 1'b0, '0);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_words);
    int k, w, cap, cap_h, pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    close_frame();
    for (k = 0; k < n_words; k++) begin
      if (col_pos == 0 && row_pos == 0) begin
        if ($urandom_range(0, 99) < 30) begin
          pick = $urandom_range(0, 99);
          w = (pick < 5) ? 0 : (pick < 10) ? 1 :
              (pick < 85) ? $urandom_range(2, 12) : $urandom_range(13, 48);
          write_frame(CFG_W'(w), CFG_W'($urandom_range(0, 6)));
        end
      end else if ($urandom_range(0, 199) < 3) begin
        // Mid-frame the width and the height may only shrink, so that a last
        // row never turns into one whose successor reads unwritten columns.
        cap   = (frame_w < 1) ? 1 : (frame_w > MAX_W) ? MAX_W : frame_w;
        cap_h = (frame_h < 1) ? 1 : frame_h;
        write_frame(CFG_W'($urandom_range(0, cap)), CFG_W'($urandom_range(0, cap_h)));
      end
      send_pixel(rand_pixel(), 1'b0, '0);
    end
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset frame size, then a mid-row shrink to three columns and two rows.
    plan.push_back(mk_checked(0, 0, 0, 0, 1'b0));
    plan.push_back(mk_checked(255, 255, 255, 251, 1'b0));
    plan.push_back(mk_pixel(25, 21, 25));
    plan.push_back(mk_pixel(26, 22, 26));
    plan.push_back(mk_pixel(128, 127, 200));
    plan.push_back(mk_write(REG_WIDTH, 3));
    plan.push_back(mk_pixel(250, 250, 250));
    plan.push_back(mk_write(REG_HEIGHT, 2));
    plan.push_back(mk_pixel(25, 0, 25));
    plan.push_back(mk_pixel(250, 0, 250));
    plan.push_back(mk_pixel(26, 255, 26));
    // Negative error carried east drives the next pixel below zero.
    plan.push_back(mk_pixel(26, 22, 26));
    plan.push_back(mk_pixel(5, 5, 5));
    plan.push_back(mk_pixel(0, 128, 255));
    plan.push_back(mk_pixel(1, 2, 3));
    plan.push_back(mk_pixel(254, 253, 252));
    plan.push_back(mk_pixel(100, 150, 200));
    // Zero width and height behave as a single-pixel frame.
    plan.push_back(mk_write(REG_WIDTH, 0));
    plan.push_back(mk_write(REG_HEIGHT, 0));
    plan.push_back(mk_checked(255, 0, 255, 215, 1'b1));
    plan.push_back(mk_checked(0, 255, 0, 36, 1'b1));
    plan.push_back(mk_checked(25, 21, 25, 0, 1'b1));
    plan.push_back(mk_checked(26, 22, 26, 49, 1'b1));
    plan.push_back(mk_write(REG_WIDTH, 4095));
    plan.push_back(mk_write(REG_HEIGHT, 4095));
    plan.push_back(mk_pixel(255, 255, 255));
    plan.push_back(mk_pixel(0, 0, 0));
    plan.push_back(mk_pixel(25, 26, 25));
    plan.push_back(mk_pixel(230, 21, 77));

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    run_phase(30, 76, 350);
    run_phase(76, 30, 350);

    // One long row on a wide frame, read back in part by a second row.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    close_frame();
    write_frame(12'd1200, 12'd2);
    repeat (1200 + 20) send_pixel(rand_pixel(), 1'b0, '0);
    write_frame(CFG_W'($urandom_range(1, 20)), 12'd2);
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel(), 1'b0, '0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
